### rtl/scc_pkg.sv
package scc_pkg;

  // Default build size of the frame table and of a page number.
  localparam int FRAMES_DEFAULT    = 16;
  localparam int PAGE_BITS_DEFAULT = 20;

  // Fixed field widths of the configuration register and of the result.
  localparam int ACTIVE_W    = 5;
  localparam int FRAME_IDX_W = 4;
  localparam int FAULT_W     = 32;

  // Value of the active frame count after reset.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

### rtl/scc_ram.sv
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/second_chance_clock_replacement.sv
// Second-chance (clock) page replacement unit. Each transfer on the command
// side is one page reference: it is taken at a rising edge where start is high
// and busy is low, and exactly one result follows, shown for a single cycle
// with result_valid_o high. The receiver cannot stall, so it must capture the
// result in that cycle. A reference first walks the resident frames in the
// page table memory, one read per cycle, up to the number of filled frames
// (capped at the active count). A hit, or a miss while free frames remain,
// ends there. A miss on a full table then sweeps the clock hand over the
// reference bits, one frame per cycle, until it finds a clear bit, then reads
// out the victim page and writes the new one. Busy drops in the same cycle
// as the result strobe, so the next reference can be taken at the edge that
// ends the result cycle. The active frame count may only be written while
// busy is low and no result is pending.
module second_chance_clock_replacement #(
  parameter int FRAMES    = scc_pkg::FRAMES_DEFAULT,
  parameter int PAGE_BITS = scc_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [PAGE_BITS-1:0]              page_number_i,
  input  logic                              active_frames_we_i,
  input  logic [scc_pkg::ACTIVE_W-1:0]      active_frames_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [scc_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic                              evicted_valid_o,
  output logic [PAGE_BITS-1:0]              evicted_page_o,
  output logic [scc_pkg::FAULT_W-1:0]       fault_total_o
);

  // Index width into the frame table and width of a count of frames.
  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW = $clog2(FRAMES + 1);
  localparam int CmpW = (CntW > scc_pkg::ACTIVE_W) ? CntW : scc_pkg::ACTIVE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_EVICT  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [scc_pkg::ACTIVE_W-1:0] active_q;

  // Per-reference context captured when the command is taken.
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [CntW-1:0]      eff_q, eff_d;
  logic [CntW-1:0]      used_q, used_d;

  // Search pointer: idx_q is the next address to read, cmp_idx_q the address
  // whose data arrives from the memory in this cycle.
  logic [CntW-1:0] idx_q, idx_d;
  logic            cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;

  logic [IdxW-1:0] hand_q, hand_d;
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic [CntW-1:0] filled_q, filled_d;
  logic [scc_pkg::FAULT_W-1:0] fault_q, fault_d;

  // Reference bits live in flip-flops so that reset clears them at once.
  logic [FRAMES-1:0] ref_q;
  logic              ref_we;
  logic [IdxW-1:0]   ref_waddr;
  logic              ref_wdata;

  // Result registers.
  logic                            res_valid_q, res_valid_d;
  logic                            res_hit_q, res_hit_d;
  logic [IdxW-1:0]                 res_frame_q, res_frame_d;
  logic                            res_ev_valid_q, res_ev_valid_d;
  logic [PAGE_BITS-1:0]            res_ev_page_q, res_ev_page_d;

  // Page table memory ports.
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic                 ram_re;
  logic [IdxW-1:0]      ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  logic [CmpW-1:0] act_ext;
  logic [CmpW-1:0] eff_ext;
  logic            accept;
  logic            issue;
  logic [CntW-1:0] sweep_inc;
  logic [IdxW-1:0] sweep_nxt;
  logic [scc_pkg::FAULT_W-1:0] fault_inc;

  scc_ram #(
    .WIDTH(PAGE_BITS),
    .DEPTH(FRAMES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(page_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // An active count of zero behaves as one, and one above the built size
  // behaves as the built size.
  always_comb begin
    act_ext = CmpW'(active_q);
    if (act_ext == '0) begin
      eff_ext = CmpW'(1);
    end else if (act_ext > CmpW'(FRAMES)) begin
      eff_ext = CmpW'(FRAMES);
    end else begin
      eff_ext = act_ext;
    end
  end

  // The hand steps forward and wraps at the active count.
  assign sweep_inc = CntW'(sweep_q) + CntW'(1);
  assign sweep_nxt = (sweep_inc < eff_q) ? IdxW'(sweep_inc) : '0;

  assign fault_inc = (fault_q != '1) ? fault_q + 1'b1 : fault_q;
  assign issue     = (state_q == S_SEARCH) && (idx_q < used_q);

  always_comb begin
    state_d        = state_q;
    page_d         = page_q;
    eff_d          = eff_q;
    used_d         = used_q;
    idx_d          = idx_q;
    cmp_valid_d    = 1'b0;
    cmp_idx_d      = cmp_idx_q;
    hand_d         = hand_q;
    sweep_d        = sweep_q;
    filled_d       = filled_q;
    fault_d        = fault_q;
    res_valid_d    = 1'b0;
    res_hit_d      = res_hit_q;
    res_frame_d    = res_frame_q;
    res_ev_valid_d = res_ev_valid_q;
    res_ev_page_d  = res_ev_page_q;
    ref_we         = 1'b0;
    ref_waddr      = sweep_q;
    ref_wdata      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = sweep_q;
    ram_re         = 1'b0;
    ram_raddr      = IdxW'(idx_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          page_d  = page_number_i;
          eff_d   = CntW'(eff_ext);
          used_d  = (filled_q < CntW'(eff_ext)) ? filled_q : CntW'(eff_ext);
          idx_d   = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (issue) begin
          ram_re      = 1'b1;
          idx_d       = idx_q + 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d   = IdxW'(idx_q);
        end
        if (cmp_valid_q && (ram_rdata == page_q)) begin
          // Hit: give the frame its second chance.
          ref_we         = 1'b1;
          ref_waddr      = cmp_idx_q;
          ref_wdata      = 1'b1;
          res_valid_d    = 1'b1;
          res_hit_d      = 1'b1;
          res_frame_d    = cmp_idx_q;
          res_ev_valid_d = 1'b0;
          res_ev_page_d  = '0;
          cmp_valid_d    = 1'b0;
          state_d        = S_IDLE;
        end else if (!issue && !cmp_valid_q) begin
          fault_d = fault_inc;
          if (filled_q < eff_q) begin
            // Miss with a free frame: fill it with its bit clear.
            ram_we         = 1'b1;
            ram_waddr      = IdxW'(filled_q);
            ref_we         = 1'b1;
            ref_waddr      = IdxW'(filled_q);
            ref_wdata      = 1'b0;
            filled_d       = filled_q + 1'b1;
            res_valid_d    = 1'b1;
            res_hit_d      = 1'b0;
            res_frame_d    = IdxW'(filled_q);
            res_ev_valid_d = 1'b0;
            res_ev_page_d  = '0;
            state_d        = S_IDLE;
          end else begin
            // Miss on a full table: a hand left beyond the active count
            // restarts at frame zero.
            sweep_d = (CntW'(hand_q) < eff_q) ? hand_q : '0;
            state_d = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (ref_q[sweep_q]) begin
          ref_we    = 1'b1;
          ref_waddr = sweep_q;
          ref_wdata = 1'b0;
          sweep_d   = sweep_nxt;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sweep_q;
          state_d   = S_EVICT;
        end
      end
      S_EVICT: begin
        // The victim page arrives from the memory while the new one goes in.
        ram_we         = 1'b1;
        ram_waddr      = sweep_q;
        ref_we         = 1'b1;
        ref_waddr      = sweep_q;
        ref_wdata      = 1'b0;
        hand_d         = sweep_nxt;
        res_valid_d    = 1'b1;
        res_hit_d      = 1'b0;
        res_frame_d    = sweep_q;
        res_ev_valid_d = 1'b1;
        res_ev_page_d  = ram_rdata;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= scc_pkg::ACTIVE_RESET;
      cmp_valid_q <= 1'b0;
      hand_q      <= '0;
      filled_q    <= '0;
      fault_q     <= '0;
      ref_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= cmp_valid_d;
      hand_q      <= hand_d;
      filled_q    <= filled_d;
      fault_q     <= fault_d;
      res_valid_q <= res_valid_d;
      if (active_frames_we_i) begin
        active_q <= active_frames_i;
      end
      if (ref_we) begin
        ref_q[ref_waddr] <= ref_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q         <= page_d;
    eff_q          <= eff_d;
    used_q         <= used_d;
    idx_q          <= idx_d;
    cmp_idx_q      <= cmp_idx_d;
    sweep_q        <= sweep_d;
    res_hit_q      <= res_hit_d;
    res_frame_q    <= res_frame_d;
    res_ev_valid_q <= res_ev_valid_d;
    res_ev_page_q  <= res_ev_page_d;
  end

  assign result_valid_o  = res_valid_q;
  assign hit_o           = res_hit_q;
  assign frame_index_o   = scc_pkg::FRAME_IDX_W'(res_frame_q);
  assign evicted_valid_o = res_ev_valid_q;
  assign evicted_page_o  = res_ev_page_q;
  assign fault_total_o   = fault_q;

  // A taken command keeps the block busy until its result is shown.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command taken but block not busy");

  // The result strobe only appears as the block returns to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  // A replacement is always a fault, and a fault is always counted.
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_valid_o) |-> (!hit_o && (fault_total_o != '0)))
    else $error("eviction reported without a counted fault");

  // The fill count never passes the built frame count.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(FRAMES))
    else $error("fill count beyond frame table size");

endmodule
